### hw/rtl/rrts_pkg.sv
// rrts_pkg: shared types and constants of the round-robin thread scheduler
// used by the channel interfaces and the scheduler top level
package rrts_pkg;

  localparam int unsigned NumThreads      = 16;
  localparam int unsigned TidW            = $clog2(NumThreads);
  localparam int unsigned CntW            = TidW + 1;
  localparam int unsigned MaxPreemptDepth = 15;
  localparam int unsigned DepthW          = $clog2(MaxPreemptDepth + 1);
  localparam int unsigned KindW           = 4;
  localparam int unsigned TimeW           = 32;
  localparam int unsigned SliceW          = 16;
  localparam int unsigned FaultW          = 2;

  localparam logic [SliceW-1:0] SliceReset = 16'd10;

  typedef enum logic [KindW-1:0] {
    KindSchedule  = 4'd0,
    KindForce     = 4'd1,
    KindActivate  = 4'd2,
    KindExit      = 4'd3,
    KindIdle      = 4'd4,
    KindPreOff    = 4'd5,
    KindPreOn     = 4'd6,
    KindQuery     = 4'd7,
    KindCreate    = 4'd8
  } kind_e;

  typedef enum logic [2:0] {
    StBlocked   = 3'd0,
    StActive    = 3'd1,
    StFinishing = 3'd2,
    StFinished  = 3'd3,
    StIdle      = 3'd4
  } thread_state_e;

  typedef enum logic [FaultW-1:0] {
    FaultNone      = 2'd0,
    FaultPreemptOff = 2'd1,
    FaultQueueFull = 2'd2,
    FaultIdleSet   = 2'd3
  } fault_e;

endpackage

### hw/rtl/rrts_evt_if.sv
// rrts_evt_if: event channel into the scheduler, valid/ready with payload
// depends on rrts_pkg
interface rrts_evt_if import rrts_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KindW-1:0] kind;
  logic [TidW-1:0]  thread_id;
  logic [TimeW-1:0] now;

  modport source (output valid, kind, thread_id, now, input ready);
  modport sink   (input valid, kind, thread_id, now, output ready);
endinterface

### hw/rtl/rrts_res_if.sv
// rrts_res_if: result channel out of the scheduler, valid/ready with payload
// depends on rrts_pkg
interface rrts_res_if import rrts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              switched;
  logic [TidW-1:0]   running_thread;
  logic [TidW-1:0]   previous_thread;
  logic [2:0]        queried_state;
  logic [FaultW-1:0] fault;

  modport source (output valid, switched, running_thread, previous_thread, queried_state,
                  fault, input ready);
  modport sink   (input valid, switched, running_thread, previous_thread, queried_state,
                  fault, output ready);
endinterface

### hw/rtl/round_robin_thread_scheduler.sv
// round_robin_thread_scheduler: run queue and thread states held in two
// synchronous memories, one read-modify-write sequence per event
// the state memory port is used in turn: S_IDLE (beat, current-thread read), S_EXEC (write back),
// S_QUERY (queried-thread read), S_OUT (result registered once the output drains); events taken in S_IDLE
// reset: thread 0 active and running, queue empty, slice length 10; thread state
// entries read as reset values until first written, no clearing pass
module round_robin_thread_scheduler import rrts_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [SliceW-1:0] cfg_wdata_i,
  rrts_evt_if.sink          evt_i,
  rrts_res_if.source        res_o
);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_QUERY, S_OUT} seq_e;

  seq_e seq_q;

  // latched event
  kind_e            kind_q;
  logic [TidW-1:0]  tid_q;
  logic [TimeW-1:0] now_q;

  // scalar state
  logic [SliceW-1:0] slice_len_q;
  logic [TidW-1:0]   head_q, head_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [TidW-1:0]   cur_q, cur_d;
  logic [TidW-1:0]   idle_id_q, idle_id_d;
  logic              idle_pres_q, idle_pres_d;
  logic [TimeW-1:0]  slice_start_q, slice_start_d;
  logic [DepthW-1:0] depth_q, depth_d;

  // result registers
  logic              sw_q, sw_d;
  logic [TidW-1:0]   prev_q;
  fault_e            fault_q, fault_d;
  logic              res_valid_q;
  logic              res_sw_q;
  logic [TidW-1:0]   res_run_q, res_prev_q;
  logic [2:0]        res_qs_q;
  fault_e            res_fault_q;

  // thread state memory
  thread_state_e ts_mem [NumThreads];
  logic [NumThreads-1:0] ts_vld_q;
  logic              ts_re, ts_we;
  logic [TidW-1:0]   ts_raddr, ts_waddr;
  thread_state_e     ts_wdata, ts_rdata_q, ts_rd;
  logic              ts_rvld_q;
  logic [TidW-1:0]   ts_raddr_q;

  // run queue memory
  logic [TidW-1:0] rq_mem [NumThreads];
  logic            rq_we;
  logic [TidW-1:0] rq_waddr, rq_wdata, rq_rdata_q;

  logic evt_beat;
  assign evt_beat    = evt_i.valid && evt_i.ready;
  assign evt_i.ready = (seq_q == S_IDLE);

  assign ts_re    = (seq_q == S_IDLE) || (seq_q == S_QUERY);
  assign ts_raddr = (seq_q == S_QUERY) ? tid_q : cur_q;

  always_ff @(posedge clk_i) begin
    if (ts_we) begin
      ts_mem[ts_waddr] <= ts_wdata;
    end
    if (ts_re) begin
      ts_rdata_q <= ts_mem[ts_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_vld_q   <= '0;
      ts_rvld_q  <= 1'b0;
      ts_raddr_q <= '0;
    end else begin
      if (ts_we) begin
        ts_vld_q[ts_waddr] <= 1'b1;
      end
      if (ts_re) begin
        ts_rvld_q  <= ts_vld_q[ts_raddr];
        ts_raddr_q <= ts_raddr;
      end
    end
  end

  // unwritten entries read as their reset value
  always_comb begin
    if (ts_rvld_q) begin
      ts_rd = ts_rdata_q;
    end else if (ts_raddr_q == '0) begin
      ts_rd = StActive;
    end else begin
      ts_rd = StBlocked;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rq_we) begin
      rq_mem[rq_waddr] <= rq_wdata;
    end
    if (seq_q == S_IDLE) begin
      rq_rdata_q <= rq_mem[head_q];
    end
  end

  // event execution, evaluated in S_EXEC
  logic              do_sched, pop, push_prev, elapsed_lt, depth0, sel_idle;
  logic              idle_eff, have_next;
  logic [TidW-1:0]   idle_id_eff, next_id, head_pop;
  logic [CntW-1:0]   count_pop;
  logic [TimeW-1:0]  elapsed;
  thread_state_e     pstate;

  always_comb begin
    elapsed    = now_q - slice_start_q;
    elapsed_lt = elapsed < {{(TimeW-SliceW){1'b0}}, slice_len_q};
    depth0     = (depth_q == '0);
    sel_idle   = (kind_q == KindIdle) && !idle_pres_q;
    idle_eff    = idle_pres_q || sel_idle;
    idle_id_eff = sel_idle ? cur_q : idle_id_q;

    if (kind_q == KindExit) begin
      pstate = StFinishing;
    end else if (sel_idle) begin
      pstate = StIdle;
    end else begin
      pstate = ts_rd;
    end

    do_sched    = 1'b0;
    fault_d     = FaultNone;
    ts_we       = 1'b0;
    ts_waddr    = cur_q;
    ts_wdata    = StBlocked;
    rq_we       = 1'b0;
    rq_waddr    = head_q + count_q[TidW-1:0];
    rq_wdata    = tid_q;
    count_d     = count_q;
    head_d      = head_q;
    cur_d       = cur_q;
    slice_start_d = slice_start_q;
    depth_d     = depth_q;
    idle_id_d   = idle_id_q;
    idle_pres_d = idle_pres_q;

    unique case (kind_q)
      KindSchedule: begin
        do_sched = depth0 && !(pstate == StActive && elapsed_lt);
      end
      KindForce: begin
        if (!depth0) fault_d = FaultPreemptOff;
        else do_sched = 1'b1;
      end
      KindActivate: begin
        if (count_q[CntW-1]) begin
          fault_d = FaultQueueFull;
        end else begin
          rq_we    = 1'b1;
          count_d  = count_q + CntW'(1);
          ts_we    = 1'b1;
          ts_waddr = tid_q;
          ts_wdata = StActive;
        end
      end
      KindExit: begin
        ts_we    = 1'b1;
        ts_wdata = StFinishing;
        if (!depth0) fault_d = FaultPreemptOff;
        else do_sched = 1'b1;
      end
      KindIdle: begin
        if (idle_pres_q) begin
          fault_d = FaultIdleSet;
        end else begin
          idle_id_d   = cur_q;
          idle_pres_d = 1'b1;
          ts_we       = 1'b1;
          ts_wdata    = StIdle;
          if (!depth0) fault_d = FaultPreemptOff;
          else do_sched = 1'b1;
        end
      end
      KindPreOff: begin
        if (depth_q < DepthW'(MaxPreemptDepth)) depth_d = depth_q + DepthW'(1);
      end
      KindPreOn: begin
        if (!depth0) depth_d = depth_q - DepthW'(1);
      end
      KindCreate: begin
        ts_we    = 1'b1;
        ts_waddr = tid_q;
        ts_wdata = StBlocked;
      end
      default: begin
      end
    endcase

    // schedule: pop happens even when the switch is then dropped
    pop       = do_sched && (count_q != '0);
    head_pop  = head_q + TidW'(pop);
    count_pop = count_q - CntW'(pop);
    next_id   = pop ? rq_rdata_q : idle_id_eff;
    have_next = pop || idle_eff;
    sw_d      = do_sched && have_next && (next_id != cur_q) &&
                !(idle_eff && (next_id == idle_id_eff) && (pstate == StActive));
    push_prev = sw_d && (pstate == StActive);

    if (do_sched) begin
      head_d  = head_pop;
      count_d = count_pop;
    end
    if (sw_d) begin
      cur_d         = next_id;
      slice_start_d = now_q;
      if (pstate == StFinishing) begin
        ts_we    = 1'b1;
        ts_waddr = cur_q;
        ts_wdata = StFinished;
      end
    end
    if (push_prev) begin
      rq_we    = 1'b1;
      rq_waddr = head_pop + count_pop[TidW-1:0];
      rq_wdata = cur_q;
      count_d  = count_pop + CntW'(1);
    end

    // memories are written only in the execute cycle
    if (seq_q != S_EXEC) begin
      ts_we = 1'b0;
      rq_we = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_len_q <= SliceReset;
    end else if (cfg_we_i) begin
      slice_len_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q         <= S_IDLE;
      kind_q        <= KindSchedule;
      tid_q         <= '0;
      now_q         <= '0;
      head_q        <= '0;
      count_q       <= '0;
      cur_q         <= '0;
      idle_id_q     <= '0;
      idle_pres_q   <= 1'b0;
      slice_start_q <= '0;
      depth_q       <= '0;
      sw_q          <= 1'b0;
      prev_q        <= '0;
      fault_q       <= FaultNone;
      res_valid_q   <= 1'b0;
      res_sw_q      <= 1'b0;
      res_run_q     <= '0;
      res_prev_q    <= '0;
      res_qs_q      <= '0;
      res_fault_q   <= FaultNone;
    end else begin
      if (res_valid_q && res_o.ready && (seq_q != S_OUT)) begin
        res_valid_q <= 1'b0;
      end
      unique case (seq_q)
        S_IDLE: begin
          if (evt_beat) begin
            kind_q <= kind_e'(evt_i.kind);
            tid_q  <= evt_i.thread_id;
            now_q  <= evt_i.now;
            seq_q  <= S_EXEC;
          end
        end
        S_EXEC: begin
          head_q        <= head_d;
          count_q       <= count_d;
          cur_q         <= cur_d;
          idle_id_q     <= idle_id_d;
          idle_pres_q   <= idle_pres_d;
          slice_start_q <= slice_start_d;
          depth_q       <= depth_d;
          sw_q          <= sw_d;
          prev_q        <= cur_q;
          fault_q       <= fault_d;
          seq_q         <= S_QUERY;
        end
        S_QUERY: begin
          seq_q <= S_OUT;
        end
        S_OUT: begin
          // wait for the output register to drain
          if (!res_valid_q || res_o.ready) begin
            res_valid_q <= 1'b1;
            res_sw_q    <= sw_q;
            res_run_q   <= cur_q;
            res_prev_q  <= prev_q;
            res_qs_q    <= ts_rd;
            res_fault_q <= fault_q;
            seq_q       <= S_IDLE;
          end
        end
        default: seq_q <= S_IDLE;
      endcase
    end
  end

  assign res_o.valid           = res_valid_q;
  assign res_o.switched        = res_sw_q;
  assign res_o.running_thread  = res_run_q;
  assign res_o.previous_thread = res_prev_q;
  assign res_o.queried_state   = res_qs_q;
  assign res_o.fault           = res_fault_q;

endmodule
